FILE: hdl/ubxv_pkg.sv
// ubxv_pkg: constants and types shared by the velocity frame parser
// no dependencies
`timescale 1ns / 1ps

package ubxv_pkg;

    localparam logic [7:0] SYNC_ONE        = 8'hB5;
    localparam logic [7:0] SYNC_TWO        = 8'h62;
    localparam logic [7:0] CLASS_VEL       = 8'h01;
    localparam logic [7:0] ID_VEL          = 8'h12;

    localparam int         FRAME_BYTES     = 44;
    localparam int         FIRST_WORD_BYTE = 6;
    localparam int         OUT_FIELDS      = 9;
    localparam int         DEF_WORD_COUNT  = 9;
    localparam int         POS_W           = 6;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [7:0]       t_byte;
    typedef logic [31:0]      t_word;

    typedef struct packed {
        logic restart;
        logic add;
    } t_sum_ctrl;

endpackage

FILE: hdl/ubx_velocity_frame_parser.sv
// ubx_velocity_frame_parser: top level, header hunt, word assembly and result register
// depends on ubxv_pkg and ubxv_fletcher
`timescale 1ns / 1ps

// Takes one receiver byte per beat and accepts a byte in every clock cycle;
// it holds off input only while a finished result waits in the output
// register and the result side is not ready. The 44-byte velocity frame
// (sync b5 62, class 01, id 12) is checked with the 8-bit fletcher sum over
// class through payload, and on a match the nine little-endian payload words
// appear as one result beat the cycle after the last checksum byte is taken.
// A failed checksum gives no beat. The header hunt restarts at the byte after
// a frame; a b5 in a broken header re-arms the hunt.
module ubx_velocity_frame_parser #(
    parameter int WORD_COUNT = ubxv_pkg::DEF_WORD_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic        [7:0]  i_rx_byte,
    output logic               o_vel_valid,
    input  logic               i_vel_ready,
    output logic signed [31:0] o_time_of_week,
    output logic signed [31:0] o_vel_north,
    output logic signed [31:0] o_vel_east,
    output logic signed [31:0] o_vel_down,
    output logic signed [31:0] o_speed_3d,
    output logic signed [31:0] o_ground_speed,
    output logic signed [31:0] o_heading_word,
    output logic signed [31:0] o_speed_accuracy,
    output logic signed [31:0] o_course_accuracy
);
    import ubxv_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SYNC1 = 3'd1;
    localparam logic [2:0] PH_SYNC2 = 3'd2;
    localparam logic [2:0] PH_CLASS = 3'd3;
    localparam logic [2:0] PH_BODY  = 3'd4;

    localparam t_pos POS_BODY   = t_pos'(4);
    localparam t_pos POS_FIRST  = t_pos'(FIRST_WORD_BYTE);
    localparam t_pos POS_END    = t_pos'(FIRST_WORD_BYTE + 4 * WORD_COUNT);
    localparam t_pos POS_CK_LOW = t_pos'(FRAME_BYTES - 2);
    localparam t_pos POS_LAST   = t_pos'(FRAME_BYTES - 1);

    logic      [2:0] r_phase, n_phase;
    t_pos            r_pos, n_pos;
    t_byte           r_ck_low;
    t_word           r_store [WORD_COUNT];
    t_word           r_res   [OUT_FIELDS];
    logic            r_vel_valid, n_vel_valid;

    logic            rx_fire;
    logic      [2:0] restart;
    t_sum_ctrl       sum_ctrl;
    t_byte           sum_a, sum_b;
    logic            in_body_sum, in_words, is_last, ck_ok;
    t_pos            rel;
    t_word           res_next [OUT_FIELDS];

    assign o_rx_ready = !r_vel_valid || i_vel_ready;
    assign rx_fire    = i_rx_valid && o_rx_ready;
    assign restart    = (i_rx_byte == SYNC_ONE) ? PH_SYNC1 : PH_IDLE;

    assign in_body_sum = (r_phase == PH_BODY) && (r_pos < POS_CK_LOW);
    assign in_words    = in_body_sum && (r_pos >= POS_FIRST) && (r_pos < POS_END);
    assign rel         = r_pos - POS_FIRST;
    assign is_last     = (r_phase == PH_BODY) && (r_pos == POS_LAST);
    assign ck_ok       = (r_ck_low == sum_a) && (i_rx_byte == sum_b);

    ubxv_fletcher u_fletcher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (sum_ctrl),
        .i_byte  (i_rx_byte),
        .o_sum_a (sum_a),
        .o_sum_b (sum_b)
    );

    always_comb begin
        n_phase          = r_phase;
        n_pos            = r_pos;
        sum_ctrl.restart = 1'b0;
        sum_ctrl.add     = 1'b0;
        if (rx_fire) begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_phase = restart;
                end
                PH_SYNC1: begin
                    n_phase = (i_rx_byte == SYNC_TWO) ? PH_SYNC2 : restart;
                end
                PH_SYNC2: begin
                    if (i_rx_byte == CLASS_VEL) begin
                        sum_ctrl.restart = 1'b1;
                        sum_ctrl.add     = 1'b1;
                        n_phase          = PH_CLASS;
                    end else begin
                        n_phase = restart;
                    end
                end
                PH_CLASS: begin
                    if (i_rx_byte == ID_VEL) begin
                        sum_ctrl.add = 1'b1;
                        n_pos        = POS_BODY;
                        n_phase      = PH_BODY;
                    end else begin
                        n_phase = restart;
                    end
                end
                PH_BODY: begin
                    sum_ctrl.add = in_body_sum;
                    if (r_pos == POS_LAST) begin
                        n_phase = PH_IDLE;
                        n_pos   = '0;
                    end else begin
                        n_pos = r_pos + t_pos'(1);
                    end
                end
                default: begin
                    n_phase = restart;
                end
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < OUT_FIELDS; k++) begin
            res_next[k] = '0;
        end
        for (int k = 0; k < WORD_COUNT; k++) begin
            res_next[k] = r_store[k];
        end
    end

    always_comb begin
        n_vel_valid = r_vel_valid;
        if (rx_fire && is_last && ck_ok) begin
            n_vel_valid = 1'b1;
        end else if (i_vel_ready) begin
            n_vel_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_ck_low    <= 8'd0;
            r_vel_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_vel_valid <= n_vel_valid;
            if (rx_fire && (r_phase == PH_BODY) && (r_pos == POS_CK_LOW)) begin
                r_ck_low <= i_rx_byte;
            end
        end
    end

    // word store, one byte lane per beat
    always_ff @(posedge i_clk) begin
        if (rx_fire && in_words) begin
            for (int k = 0; k < WORD_COUNT; k++) begin
                for (int l = 0; l < 4; l++) begin
                    if ((int'(rel[POS_W-1:2]) == k) && (int'(rel[1:0]) == l)) begin
                        r_store[k][8*l +: 8] <= i_rx_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_fire && is_last && ck_ok) begin
            for (int k = 0; k < OUT_FIELDS; k++) begin
                r_res[k] <= res_next[k];
            end
        end
    end

    assign o_vel_valid       = r_vel_valid;
    assign o_time_of_week    = r_res[0];
    assign o_vel_north       = r_res[1];
    assign o_vel_east        = r_res[2];
    assign o_vel_down        = r_res[3];
    assign o_speed_3d        = r_res[4];
    assign o_ground_speed    = r_res[5];
    assign o_heading_word    = r_res[6];
    assign o_speed_accuracy  = r_res[7];
    assign o_course_accuracy = r_res[8];

    a_body_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> ((r_pos >= POS_BODY) && (r_pos <= POS_LAST)))
        else $error("frame position out of range in body");

    a_hunt_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_BODY) |-> (r_pos == '0))
        else $error("frame position not cleared outside body");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_fire && (r_phase == PH_BODY) && (r_pos == POS_LAST) && ck_ok) |=> r_vel_valid)
        else $error("checked frame did not raise a result");

    a_result_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_vel_valid ##1 r_vel_valid) |-> $past(rx_fire && is_last && ck_ok))
        else $error("result raised without a completed frame");

endmodule

FILE: hdl/ubxv_fletcher.sv
// ubxv_fletcher: running 8-bit fletcher sum over accepted frame bytes
// depends on ubxv_pkg
`timescale 1ns / 1ps

module ubxv_fletcher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ubxv_pkg::t_sum_ctrl i_ctrl,
    input  ubxv_pkg::t_byte     i_byte,
    output ubxv_pkg::t_byte     o_sum_a,
    output ubxv_pkg::t_byte     o_sum_b
);
    import ubxv_pkg::*;

    t_byte r_sum_a, r_sum_b;
    t_byte n_sum_a, n_sum_b;
    t_byte base_a, base_b;

    always_comb begin
        base_a  = i_ctrl.restart ? 8'd0 : r_sum_a;
        base_b  = i_ctrl.restart ? 8'd0 : r_sum_b;
        n_sum_a = base_a + i_byte;
        n_sum_b = base_b + n_sum_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
        end else if (i_ctrl.add) begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
    end

    assign o_sum_a = r_sum_a;
    assign o_sum_b = r_sum_b;

endmodule
